// ===== src/assert_macros.svh =====
// Assertion macros used by clock_time_string_parser for its checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition that must never be seen at a rising clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

// ===== src/tsp_pkg.sv =====
`timescale 1ns / 1ps

package tsp_pkg;

   // Widths of the result fields.
   localparam int STATUS_W = 3;
   localparam int VALUE_W  = 10;
   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int SECOND_W = 6;
   localparam int MILLIS_W = 10;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK     = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_FORMAT = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_HOUR   = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_MINUTE = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_SECOND = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_MILLIS = 3'd5;

   // Character codes.
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // Field indexes.
   localparam logic [1:0] FIELD_HOUR   = 2'd0;
   localparam logic [1:0] FIELD_MINUTE = 2'd1;
   localparam logic [1:0] FIELD_SECOND = 2'd2;
   localparam logic [1:0] FIELD_MILLIS = 2'd3;

   // Saturation value of a field accumulator.
   localparam logic [VALUE_W-1:0] VALUE_MAX = 10'd1023;

   // Upper limits per field, hour in entry zero.
   localparam logic [3:0][VALUE_W-1:0] FIELD_LIMIT = {10'd999, 10'd59, 10'd59, 10'd23};

   // Counters saturate at this value.
   localparam logic [1:0] COUNT_MAX = 2'd3;

   // Parsing state of the text being received.
   typedef struct packed {
      logic [1:0]              field_index;
      logic [1:0]              colon_count;
      logic [1:0]              comma_count;
      logic [3:0]              nondigit;
      logic [3:0][VALUE_W-1:0] value;
   } parse_state_type;

endpackage

// ===== src/clock_time_string_parser.sv =====
`timescale 1ns / 1ps
// Time text parser for texts of the form hh:mm:ss,mmm.
// Input channel req_: one character per transaction in req_tdata, with
// req_tlast high on the final character of a text. Result channel rsp_:
// one transaction per text, sent for the final character, carrying the
// status and the stored time (which only an ok text replaces).
// Each character is first held in an input register; from there the
// parse state register is updated and, for a final character, the status
// is judged and the result register loaded, which drives rsp_tvalid.
// Throughput is one character per cycle, set by the single update step on
// the parse state register, except while a final character waits.
// When rsp_tready is low a waiting result holds; characters that do not
// end a text keep flowing, and only the next final character waits for
// the result register to be taken.
// Reset clears the parse state, the stored time, the time-set flag and
// both valid flags; rsp_tvalid is low after reset.

`include "assert_macros.svh"

module clock_time_string_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tlast,   // is_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [2:0] result_status, [3] time_set, [8:4] out_hour,
                                    // [14:9] out_minute, [20:15] out_second,
                                    // [30:21] out_millis, [31] zero
);
   import tsp_pkg::*;

   logic                in_valid_ff;
   logic                in_valid_in;
   logic [7:0]          in_char_ff;
   logic                in_last_ff;

   parse_state_type     parse_ff;
   parse_state_type     parse_in;
   parse_state_type     parse_step;
   logic [STATUS_W-1:0] status;

   logic [HOUR_W-1:0]   stored_hour_ff;
   logic [MINUTE_W-1:0] stored_minute_ff;
   logic [SECOND_W-1:0] stored_second_ff;
   logic [MILLIS_W-1:0] stored_millis_ff;
   logic                stored_valid_ff;
   logic                store_en;

   logic                out_valid_ff;
   logic                out_valid_in;
   logic [STATUS_W-1:0] out_status_ff;
   logic                out_set_ff;
   logic [HOUR_W-1:0]   out_hour_ff;
   logic [MINUTE_W-1:0] out_minute_ff;
   logic [SECOND_W-1:0] out_second_ff;
   logic [MILLIS_W-1:0] out_millis_ff;

   logic                fire;
   logic                emit;

   // The held character is processed unless it ends a text and the result slot is busy.
   assign fire       = in_valid_ff && (!in_last_ff || !out_valid_ff || rsp_tready);
   assign emit       = fire && in_last_ff;
   assign req_tready = !in_valid_ff || fire;

   // Input register.
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // Parse update and judgment.
   tsp_char_step u_char_step (
      .state_cur (parse_ff),
      .char_code (in_char_ff),
      .state_nxt (parse_step)
   );

   tsp_judge u_judge (
      .state_fin (parse_step),
      .status    (status)
   );

   assign store_en = emit && (status == STATUS_OK);

   // Parse state returns to empty after the final character of a text.
   always_comb begin
      parse_in = parse_ff;
      if (fire) begin
         parse_in = in_last_ff ? '0 : parse_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parse_ff <= '0;
      end else begin
         parse_ff <= parse_in;
      end
   end

   // Stored time, replaced only by an ok text.
   always_ff @(posedge clock) begin
      if (reset) begin
         stored_hour_ff   <= '0;
         stored_minute_ff <= '0;
         stored_second_ff <= '0;
         stored_millis_ff <= '0;
         stored_valid_ff  <= 1'b0;
      end else if (store_en) begin
         stored_hour_ff   <= parse_step.value[FIELD_HOUR][HOUR_W-1:0];
         stored_minute_ff <= parse_step.value[FIELD_MINUTE][MINUTE_W-1:0];
         stored_second_ff <= parse_step.value[FIELD_SECOND][SECOND_W-1:0];
         stored_millis_ff <= parse_step.value[FIELD_MILLIS][MILLIS_W-1:0];
         stored_valid_ff  <= 1'b1;
      end
   end

   // Result register.
   assign out_valid_in = emit || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_status_ff <= status;
         out_set_ff    <= store_en || stored_valid_ff;
         out_hour_ff   <= store_en ? parse_step.value[FIELD_HOUR][HOUR_W-1:0] : stored_hour_ff;
         out_minute_ff <= store_en ? parse_step.value[FIELD_MINUTE][MINUTE_W-1:0]
                                   : stored_minute_ff;
         out_second_ff <= store_en ? parse_step.value[FIELD_SECOND][SECOND_W-1:0]
                                   : stored_second_ff;
         out_millis_ff <= store_en ? parse_step.value[FIELD_MILLIS][MILLIS_W-1:0]
                                   : stored_millis_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_millis_ff, out_second_ff, out_minute_ff, out_hour_ff,
                        out_set_ff, out_status_ff};

   // Checks on the internal logic.
   `ASSERT_CLK(a_rsp_from_last, $rose(out_valid_ff) |-> $past(emit), "result without final character")
   `ASSERT_CLK(a_set_sticky, stored_valid_ff |=> stored_valid_ff, "time-set flag dropped")
   `ASSERT_NEVER(a_hour_range, stored_hour_ff > 5'd23, "stored hour out of range")
   `ASSERT_CLK(a_parse_clear, emit |=> (parse_ff == '0), "parse state not cleared after text")

endmodule

// ===== src/tsp_char_step.sv =====
`timescale 1ns / 1ps

module tsp_char_step (
   input  tsp_pkg::parse_state_type state_cur,
   input  logic [7:0]               char_code,
   output tsp_pkg::parse_state_type state_nxt
);
   import tsp_pkg::*;

   logic [1:0]           field;
   logic [3:0]           digit;
   logic [VALUE_W+3:0]   acc_wide;
   logic [VALUE_W+3:0]   acc_old;

   assign field   = state_cur.field_index;
   assign digit   = 4'(char_code - CHAR_ZERO);
   assign acc_old = {4'b0, state_cur.value[field]};
   // Multiply by ten as two shifts, then add the new digit.
   assign acc_wide = (acc_old << 3) + (acc_old << 1) + {{VALUE_W{1'b0}}, digit};

   // Update the parsing state with one character.
   always_comb begin
      state_nxt = state_cur;
      if (char_code == CHAR_COLON) begin
         if (state_cur.colon_count != COUNT_MAX) begin
            state_nxt.colon_count = state_cur.colon_count + 2'd1;
         end
         if (field == FIELD_HOUR || field == FIELD_MINUTE) begin
            state_nxt.field_index = field + 2'd1;
         end else begin
            state_nxt.nondigit[field] = 1'b1;
         end
      end else if (char_code == CHAR_COMMA) begin
         if (state_cur.comma_count != COUNT_MAX) begin
            state_nxt.comma_count = state_cur.comma_count + 2'd1;
         end
         if (field == FIELD_SECOND) begin
            state_nxt.field_index = FIELD_MILLIS;
         end else begin
            state_nxt.nondigit[field] = 1'b1;
         end
      end else if (char_code >= CHAR_ZERO && char_code <= CHAR_NINE) begin
         if (acc_wide > {4'b0, VALUE_MAX}) begin
            state_nxt.value[field] = VALUE_MAX;
         end else begin
            state_nxt.value[field] = acc_wide[VALUE_W-1:0];
         end
      end else begin
         state_nxt.nondigit[field] = 1'b1;
      end
   end

endmodule

// ===== src/tsp_judge.sv =====
`timescale 1ns / 1ps

module tsp_judge (
   input  tsp_pkg::parse_state_type       state_fin,
   output logic [tsp_pkg::STATUS_W-1:0]   status
);
   import tsp_pkg::*;

   logic [STATUS_W-1:0] nondigit_code;
   logic                nondigit_hit;
   logic [STATUS_W-1:0] range_code;
   logic                range_hit;

   // First field holding a non-digit; scanning down leaves the lowest one.
   always_comb begin
      nondigit_code = STATUS_OK;
      nondigit_hit  = 1'b0;
      for (int i = 3; i >= 0; i--) begin
         if (state_fin.nondigit[i]) begin
            nondigit_code = STATUS_HOUR + STATUS_W'(i);
            nondigit_hit  = 1'b1;
         end
      end
   end

   // First field whose value is above its limit.
   always_comb begin
      range_code = STATUS_OK;
      range_hit  = 1'b0;
      for (int i = 3; i >= 0; i--) begin
         if (state_fin.value[i] > FIELD_LIMIT[i]) begin
            range_code = STATUS_HOUR + STATUS_W'(i);
            range_hit  = 1'b1;
         end
      end
   end

   // Separator count is checked first, then digits, then ranges.
   always_comb begin
      if (state_fin.colon_count != 2'd2 || state_fin.comma_count != 2'd1) begin
         status = STATUS_FORMAT;
      end else if (nondigit_hit) begin
         status = nondigit_code;
      end else if (range_hit) begin
         status = range_code;
      end else begin
         status = STATUS_OK;
      end
   end

endmodule
